// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands for the mixer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define MPM_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define MPM_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mpm_pkg.sv -----
// ---------------------------------------------------------------------------
// mpm_pkg
// types and fixed constants shared by the pcm mixer modules
// ---------------------------------------------------------------------------
`default_nettype none

package mpm_pkg;

  // command codes carried in s_tuser
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_VOLUME = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic apply_cmd;   // start, stop or volume write this cycle
    logic tick_start;  // latch tick bytes, preset the sum
    logic mix_step;    // process the voice under the counter
    logic out_load;    // capture the finished result
  } ctrl_t;

  localparam int DAC_W      = 12;
  localparam int CHAN_W     = 3;
  localparam int VOL_W      = 7;
  localparam int LEN_IN_W   = 24;
  localparam int STEP_W     = 8;
  localparam int SAMPLES_W  = 64;
  localparam int MASK_W     = 8;
  localparam int MIX_SHIFT  = 6;

  localparam int S_TDATA_W  = 112;
  localparam int M_TDATA_W  = 32;

  localparam logic [DAC_W-1:0] MIX_MID = 12'd2048;
  localparam logic [DAC_W-1:0] MIX_MAX = 12'd4095;
  localparam logic [8:0]       BYTE_BIAS = 9'd128;

endpackage

`default_nettype wire

// ----- rtl/core/mpm_ctrl.sv -----
// ---------------------------------------------------------------------------
// mpm_ctrl
// command sequencer: accepts items, walks the voices, hands off results
// ---------------------------------------------------------------------------
`default_nettype none

module mpm_ctrl #(
  parameter int VOICES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  mpm_pkg::cmd_t  cmd,
  output logic           m_tvalid,
  input  logic           m_tready,
  output mpm_pkg::ctrl_t ctrl,
  output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_idx
);
  import mpm_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && cmd == CMD_TICK) state_next = ST_MIX;
      end
      ST_MIX: begin
        if (voice_idx == LAST_IDX) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    ctrl.apply_cmd  = 1'b0;
    ctrl.tick_start = 1'b0;
    ctrl.mix_step   = 1'b0;
    ctrl.out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready        = 1'b1;
        ctrl.apply_cmd  = s_tvalid && cmd != CMD_TICK;
        ctrl.tick_start = s_tvalid && cmd == CMD_TICK;
      end
      ST_MIX:  ctrl.mix_step = 1'b1;
      ST_EMIT: ctrl.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      voice_idx <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.tick_start) voice_idx <= '0;
      else if (ctrl.mix_step) voice_idx <= voice_idx + 1'b1;
      if (ctrl.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mpm_datapath.sv -----
// ---------------------------------------------------------------------------
// mpm_datapath
// voice state, shared multiply-clamp unit and result register
// ---------------------------------------------------------------------------
`default_nettype none

module mpm_datapath #(
  parameter int VOICES      = 8,
  parameter int LENGTH_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mpm_pkg::ctrl_t                   ctrl,
  input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_idx,
  input  mpm_pkg::cmd_t                    cmd,
  input  logic [mpm_pkg::CHAN_W-1:0]       channel,
  input  logic [mpm_pkg::VOL_W-1:0]        volume,
  input  logic [mpm_pkg::LEN_IN_W-1:0]     sound_length,
  input  logic [mpm_pkg::STEP_W-1:0]       sample_step,
  input  logic [mpm_pkg::SAMPLES_W-1:0]    channel_samples,
  output logic [mpm_pkg::DAC_W-1:0]        dac_sample,
  output logic [mpm_pkg::MASK_W-1:0]       active_mask,
  output logic [mpm_pkg::MASK_W-1:0]       ended_mask
);
  import mpm_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic                   voice_on     [VOICES];
  logic [VOL_W-1:0]       voice_volume [VOICES];
  logic [LENGTH_BITS-1:0] voice_position [VOICES];
  logic [LENGTH_BITS-1:0] voice_length [VOICES];
  logic [STEP_W-1:0]      voice_step   [VOICES];

  logic [SAMPLES_W-1:0]   samples;
  logic [DAC_W-1:0]       sum;
  logic [MASK_W-1:0]      ended;

  logic                   chan_ok;
  logic [VIDX_W-1:0]      chan_idx;

  logic                   play;
  logic                   at_end;
  logic [7:0]             cur_byte;
  logic [VOL_W-1:0]       cur_vol;
  logic [STEP_W-1:0]      step_eff;
  logic [LENGTH_BITS:0]   pos_sum;
  logic [LENGTH_BITS-1:0] pos_next;
  logic signed [8:0]      centered;
  logic signed [15:0]     product;
  logic signed [15:0]     scaled;
  logic signed [13:0]     mixed;
  logic [DAC_W-1:0]       sum_next;
  logic [MASK_W-1:0]      active_now;

  assign chan_ok  = 32'(channel) < 32'(VOICES);
  assign chan_idx = channel[VIDX_W-1:0];

  // per-voice mix path
  assign cur_vol  = voice_volume[voice_idx];
  assign play     = voice_on[voice_idx] && cur_vol != '0;
  assign at_end   = voice_position[voice_idx] >= voice_length[voice_idx];
  assign cur_byte = samples[{voice_idx, 3'b000} +: 8];
  assign centered = $signed({1'b0, cur_byte}) - $signed(BYTE_BIAS);
  assign product  = centered * $signed({1'b0, cur_vol});
  assign scaled   = product >>> MIX_SHIFT;
  assign mixed    = $signed({2'b00, sum}) + scaled[13:0];

  always_comb begin
    if (mixed < 14'sd0) sum_next = '0;
    else if (mixed > $signed({2'b00, MIX_MAX})) sum_next = MIX_MAX;
    else sum_next = mixed[DAC_W-1:0];
  end

  // zero step counts as one, position saturates
  assign step_eff = (voice_step[voice_idx] == '0) ? STEP_W'(1) : voice_step[voice_idx];
  assign pos_sum  = {1'b0, voice_position[voice_idx]} + (LENGTH_BITS + 1)'(step_eff);
  assign pos_next = pos_sum[LENGTH_BITS] ? '1 : pos_sum[LENGTH_BITS-1:0];

  always_comb begin
    active_now = '0;
    for (int k = 0; k < VOICES; k++) active_now[k] = voice_on[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VOICES; k++) begin
        voice_on[k]       <= 1'b0;
        voice_volume[k]   <= '0;
        voice_position[k] <= '0;
        voice_length[k]   <= '0;
        voice_step[k]     <= STEP_W'(1);
      end
    end else begin
      if (ctrl.apply_cmd && chan_ok) begin
        case (cmd)
          CMD_START: begin
            voice_on[chan_idx]       <= 1'b1;
            voice_volume[chan_idx]   <= volume;
            voice_position[chan_idx] <= '0;
            voice_length[chan_idx]   <= LENGTH_BITS'(sound_length);
            voice_step[chan_idx]     <= sample_step;
          end
          CMD_STOP: begin
            voice_on[chan_idx]     <= 1'b0;
            voice_volume[chan_idx] <= '0;
          end
          CMD_VOLUME: voice_volume[chan_idx] <= volume;
          default: ;
        endcase
      end
      if (ctrl.mix_step && play) begin
        if (at_end) begin
          voice_on[voice_idx]     <= 1'b0;
          voice_volume[voice_idx] <= '0;
        end else begin
          voice_position[voice_idx] <= pos_next;
        end
      end
    end
  end

  // tick accumulator and result register
  always_ff @(posedge clk) begin
    if (ctrl.tick_start) begin
      samples <= channel_samples;
      sum     <= MIX_MID;
      ended   <= '0;
    end else if (ctrl.mix_step && play) begin
      if (at_end) ended[voice_idx] <= 1'b1;
      else sum <= sum_next;
    end
    if (ctrl.out_load) begin
      dac_sample  <= sum;
      active_mask <= active_now;
      ended_mask  <= ended;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/multichannel_pcm_mixer.sv -----
// ---------------------------------------------------------------------------
// multichannel_pcm_mixer
// eight-voice saturating mixer of unsigned 8-bit sounds into a 12-bit dac
// ---------------------------------------------------------------------------
// Start, stop and set-volume commands produce no output transfer. A mix
// tick first latches the tick bytes, then walks the voices one per cycle
// through a single shared multiply, shift and clamp unit, then loads the
// result register. The result register frees the input side, so a new
// command is taken while the previous mix value still waits on the output;
// a tick whose result finds that register still full holds in its final
// cycle until the sink takes the older transfer.
`default_nettype none

module multichannel_pcm_mixer #(
  parameter int VOICES      = 8,   // 1..8
  parameter int LENGTH_BITS = 24   // 8..32, width of position and length
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // channel[2:0], volume[9:3], sound_length[33:10], sample_step[41:34],
  // channel_samples[105:42], zero pad[111:106]
  input  logic [111:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_tuser,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // dac_sample[11:0], active_mask[19:12], ended_mask[27:20], zero pad[31:28]
  output logic [31:0]  m_tdata
);
  import mpm_pkg::*;

  `include "assert_macros.svh"

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  cmd_t               cmd;
  ctrl_t              ctrl;
  logic [VIDX_W-1:0]  voice_idx;
  logic [DAC_W-1:0]   dac_sample;
  logic [MASK_W-1:0]  active_mask;
  logic [MASK_W-1:0]  ended_mask;

  // command kind travels on tuser
  assign cmd = cmd_t'(s_tuser);

  // sequencer: idle accepts, then one voice per cycle, then result hand-off
  mpm_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .ctrl      (ctrl),
    .voice_idx (voice_idx)
  );

  // voice table, shared mix unit and result register
  mpm_datapath #(
    .VOICES      (VOICES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .voice_idx       (voice_idx),
    .cmd             (cmd),
    .channel         (s_tdata[2:0]),
    .volume          (s_tdata[9:3]),
    .sound_length    (s_tdata[33:10]),
    .sample_step     (s_tdata[41:34]),
    .channel_samples (s_tdata[105:42]),
    .dac_sample      (dac_sample),
    .active_mask     (active_mask),
    .ended_mask      (ended_mask)
  );

  // pack the result transfer, lowest field first
  assign m_tdata = {4'b0000, ended_mask, active_mask, dac_sample};

  // a tick blocks further input while the voices are walked
  `MPM_ASSERT_NXT(a_tick_holds_input, clk, rst, s_tvalid && s_tready && cmd == CMD_TICK, !s_tready, "input taken during mix")
  // a voice stopped at its end is never reported as still playing
  `MPM_ASSERT_IMP(a_ended_not_active, clk, rst, m_tvalid, (m_tdata[19:12] & m_tdata[27:20]) == 8'h00, "voice both ended and active")
  // loading the result always raises the output valid
  `MPM_ASSERT_NXT(a_load_sets_valid, clk, rst, ctrl.out_load, m_tvalid, "result loaded without valid")

endmodule

`default_nettype wire
